/* hw/rtl/pps_pkg.sv */
// shared types and constants for the preemptive priority scheduler
package pps_pkg;

    // fixed field widths
    localparam int SLOT_BITS  = 4;
    localparam int COUNT_BITS = 5;

    // input item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // controller states
    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MIN_SCAN,
        ST_SEL_SCAN,
        ST_UPDATE,
        ST_REPORT
    } pps_state_t;

    // commands from controller to datapath
    typedef struct packed
    {
        logic load_wr;
        logic scan_clear;
        logic scan_run;
        logic scan_sel;
        logic start_clock;
        logic update;
        logic report;
    } pps_cmd_t;

    // status from datapath to controller
    typedef struct packed
    {
        logic scan_done;
        logic started;
    } pps_status_t;

endpackage

/* hw/rtl/pps_ctrl.sv */
// controller state machine for the scheduler tick sequence
module pps_ctrl
    import pps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        kind,
    input  pps_status_t status,
    output pps_cmd_t    cmd,
    output logic        busy
);

    pps_state_t state_reg;
    pps_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (kind == KIND_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next = status.started ? ST_SEL_SCAN : ST_MIN_SCAN;
                    end
                end
            end
            ST_MIN_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.scan_done)
                begin
                    cmd.start_clock = 1'b1;
                    cmd.scan_clear  = 1'b1;
                    state_next      = ST_SEL_SCAN;
                end
            end
            ST_SEL_SCAN:
            begin
                cmd.scan_run = 1'b1;
                cmd.scan_sel = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/pps_datapath.sv */
// process table, scan unit, clock and result registers of the scheduler
module pps_datapath
    import pps_pkg::*;
#(
    parameter int MAX_PROCESSES = 16,
    parameter int TIME_BITS     = 16,
    parameter int PRIORITY_BITS = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pps_cmd_t                 cmd,
    output pps_status_t              status,
    input  logic                     cfg_write,
    input  logic [COUNT_BITS-1:0]    cfg_data,
    input  logic [SLOT_BITS-1:0]     slot,
    input  logic [TIME_BITS-1:0]     arrival_time,
    input  logic [TIME_BITS-1:0]     burst_length,
    input  logic [PRIORITY_BITS-1:0] priority_level,
    output logic                     done,
    output logic                     ran,
    output logic [SLOT_BITS-1:0]     process_number,
    output logic [TIME_BITS-1:0]     slot_time,
    output logic                     switched,
    output logic                     completed,
    output logic [TIME_BITS-1:0]     finish_time,
    output logic [TIME_BITS-1:0]     waiting_time,
    output logic [TIME_BITS-1:0]     turnaround_time,
    output logic                     all_done
);

    localparam int IDX_BITS = $clog2(MAX_PROCESSES);
    localparam int CNT_BITS = $clog2(MAX_PROCESSES + 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // process table
    logic [TIME_BITS-1:0]     arr_mem [MAX_PROCESSES];
    logic [TIME_BITS-1:0]     bur_mem [MAX_PROCESSES];
    logic [PRIORITY_BITS-1:0] pri_mem [MAX_PROCESSES];
    logic [TIME_BITS-1:0]     rem_mem [MAX_PROCESSES];
    logic [MAX_PROCESSES-1:0] rem_valid_reg;

    logic [TIME_BITS-1:0]     arr_rd_reg;
    logic [TIME_BITS-1:0]     bur_rd_reg;
    logic [PRIORITY_BITS-1:0] pri_rd_reg;
    logic [TIME_BITS-1:0]     rem_rd_reg;
    logic                     rem_vld_rd_reg;
    logic [TIME_BITS-1:0]     rem_rd;

    // configuration and scheduler state
    logic [COUNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]      n_used;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic                     rd_vld_reg;
    logic [IDX_BITS-1:0]      rd_idx_reg;
    logic [IDX_BITS-1:0]      rd_addr;
    logic                     issue;
    logic [TIME_BITS-1:0]     ct_reg;
    logic                     started_reg;
    logic [IDX_BITS-1:0]      lr_reg;
    logic                     lr_valid_reg;

    // scan accumulators
    logic [TIME_BITS-1:0]     min_arr_reg;
    logic                     work_reg;
    logic                     found_reg;
    logic [IDX_BITS-1:0]      best_idx_reg;
    logic [PRIORITY_BITS-1:0] best_pri_reg;
    logic [TIME_BITS-1:0]     best_arr_reg;
    logic [TIME_BITS-1:0]     best_bur_reg;
    logic [TIME_BITS-1:0]     best_rem_reg;
    logic                     better;

    // table write port
    logic                     load_ok;
    logic [IDX_BITS-1:0]      load_idx;
    logic                     rem_we;
    logic [IDX_BITS-1:0]      rem_waddr;
    logic [TIME_BITS-1:0]     rem_wdata;

    // update arithmetic
    logic [TIME_BITS-1:0]     fin;
    logic [TIME_BITS-1:0]     turn;

    // result registers
    logic                     done_reg;
    logic                     ran_reg;
    logic [SLOT_BITS-1:0]     pn_reg;
    logic [TIME_BITS-1:0]     slot_time_reg;
    logic                     switched_reg;
    logic                     completed_reg;
    logic [TIME_BITS-1:0]     finish_reg;
    logic [TIME_BITS-1:0]     wait_reg;
    logic [TIME_BITS-1:0]     turn_reg;
    logic                     all_done_reg;

    // entries in use, clamped to the table size
    assign n_used = (int'(count_reg) > MAX_PROCESSES) ? CNT_BITS'(MAX_PROCESSES)
                                                      : CNT_BITS'(count_reg);

    assign rd_addr = cnt_reg[IDX_BITS-1:0];
    assign issue   = cmd.scan_run && !cmd.scan_clear && (cnt_reg < n_used);
    assign rem_rd  = rem_vld_rd_reg ? rem_rd_reg : '0;

    // loads beyond the table are dropped
    assign load_ok  = cmd.load_wr && (int'(slot) < MAX_PROCESSES);
    assign load_idx = IDX_BITS'(slot);

    assign rem_we    = load_ok || (cmd.update && found_reg);
    assign rem_waddr = cmd.update ? best_idx_reg : load_idx;
    assign rem_wdata = cmd.update ? best_rem_reg - TIME_BITS'(1) : burst_length;

    // table memories with registered read
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            arr_mem[load_idx] <= arrival_time;
            bur_mem[load_idx] <= burst_length;
            pri_mem[load_idx] <= priority_level;
        end
        if (rem_we)
        begin
            rem_mem[rem_waddr] <= rem_wdata;
        end
        arr_rd_reg <= arr_mem[rd_addr];
        bur_rd_reg <= bur_mem[rd_addr];
        pri_rd_reg <= pri_mem[rd_addr];
        rem_rd_reg <= rem_mem[rd_addr];
    end

    // remaining-work valid bits, an entry never loaded has no work
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_valid_reg  <= '0;
            rem_vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (load_ok)
            begin
                rem_valid_reg[load_idx] <= 1'b1;
            end
            rem_vld_rd_reg <= rem_valid_reg[rd_addr];
        end
    end

    // candidate beats the current best
    assign better = !found_reg || (pri_rd_reg < best_pri_reg) ||
                    ((pri_rd_reg == best_pri_reg) && (arr_rd_reg < best_arr_reg));

    // saturating finish and turnaround
    assign fin  = (ct_reg == TIME_MAX) ? ct_reg : ct_reg + TIME_BITS'(1);
    assign turn = (fin > best_arr_reg) ? fin - best_arr_reg : '0;

    // scan, clock and runner control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            ct_reg       <= '0;
            started_reg  <= 1'b0;
            lr_reg       <= '0;
            lr_valid_reg <= 1'b0;
            work_reg     <= 1'b0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                count_reg <= cfg_data;
            end
            done_reg <= cmd.report;
            if (cmd.scan_clear)
            begin
                cnt_reg    <= '0;
                rd_vld_reg <= 1'b0;
                work_reg   <= 1'b0;
                found_reg  <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                rd_vld_reg <= issue;
                if (issue)
                begin
                    cnt_reg <= cnt_reg + CNT_BITS'(1);
                end
                if (rd_vld_reg && cmd.scan_sel && (rem_rd != '0))
                begin
                    work_reg <= 1'b1;
                    if ((arr_rd_reg <= ct_reg) && better)
                    begin
                        found_reg <= 1'b1;
                    end
                end
            end
            if (cmd.start_clock)
            begin
                ct_reg      <= min_arr_reg;
                started_reg <= 1'b1;
            end
            if (cmd.update)
            begin
                if (found_reg)
                begin
                    lr_reg       <= best_idx_reg;
                    lr_valid_reg <= 1'b1;
                end
                if (work_reg && (ct_reg != TIME_MAX))
                begin
                    ct_reg <= ct_reg + TIME_BITS'(1);
                end
            end
        end
    end

    // scan payload: earliest arrival and best candidate
    always_ff @(posedge clk)
    begin
        if (cmd.scan_clear)
        begin
            min_arr_reg <= '0;
        end
        else if (cmd.scan_run && rd_vld_reg)
        begin
            if (!cmd.scan_sel)
            begin
                if ((rd_idx_reg == '0) || (arr_rd_reg < min_arr_reg))
                begin
                    min_arr_reg <= arr_rd_reg;
                end
            end
            else if ((rem_rd != '0) && (arr_rd_reg <= ct_reg) && better)
            begin
                best_idx_reg <= rd_idx_reg;
                best_pri_reg <= pri_rd_reg;
                best_arr_reg <= arr_rd_reg;
                best_bur_reg <= bur_rd_reg;
                best_rem_reg <= rem_rd;
            end
        end
        if (issue)
        begin
            rd_idx_reg <= rd_addr;
        end
    end

    // result fields
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            slot_time_reg <= ct_reg;
            all_done_reg  <= !work_reg;
            ran_reg       <= found_reg;
            pn_reg        <= found_reg ? SLOT_BITS'(best_idx_reg) : '0;
            switched_reg  <= found_reg && (!lr_valid_reg || (lr_reg != best_idx_reg));
            if (found_reg && (best_rem_reg == TIME_BITS'(1)))
            begin
                completed_reg <= 1'b1;
                finish_reg    <= fin;
                turn_reg      <= turn;
            end
            else
            begin
                completed_reg <= 1'b0;
                finish_reg    <= '0;
                turn_reg      <= '0;
            end
        end
        if (cmd.report)
        begin
            wait_reg <= (completed_reg && (turn_reg > best_bur_reg))
                        ? turn_reg - best_bur_reg : '0;
        end
    end

    assign status.scan_done = cmd.scan_run && !issue && !rd_vld_reg;
    assign status.started   = started_reg;

    assign done            = done_reg;
    assign ran             = ran_reg;
    assign process_number  = pn_reg;
    assign slot_time       = slot_time_reg;
    assign switched        = switched_reg;
    assign completed       = completed_reg;
    assign finish_time     = finish_reg;
    assign waiting_time    = wait_reg;
    assign turnaround_time = turn_reg;
    assign all_done        = all_done_reg;

endmodule

/* hw/rtl/preemptive_priority_scheduler_core.sv */
// load item: taken while idle, no result; busy stays low
// tick item: busy over the table scan, update and report states; done is registered from report
// with no entries in use the scan ends without reading the table
// first tick after reset adds an earliest-arrival scan of the entries in use before the table scan
// throughput set by the one-entry-per-cycle table scan; result register frees the next start
// reset clears the clock, last runner, entry count and remaining-work valid bits; done cannot stall
module preemptive_priority_scheduler_core
    import pps_pkg::*;
#(
    parameter int MAX_PROCESSES = 16,
    parameter int TIME_BITS     = 16,
    parameter int PRIORITY_BITS = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [COUNT_BITS-1:0]    cfg_data,
    input  logic                     start,
    output logic                     busy,
    input  logic                     kind,
    input  logic [SLOT_BITS-1:0]     slot,
    input  logic [TIME_BITS-1:0]     arrival_time,
    input  logic [TIME_BITS-1:0]     burst_length,
    input  logic [PRIORITY_BITS-1:0] priority_level,
    output logic                     done,
    output logic                     ran,
    output logic [SLOT_BITS-1:0]     process_number,
    output logic [TIME_BITS-1:0]     slot_time,
    output logic                     switched,
    output logic                     completed,
    output logic [TIME_BITS-1:0]     finish_time,
    output logic [TIME_BITS-1:0]     waiting_time,
    output logic [TIME_BITS-1:0]     turnaround_time,
    output logic                     all_done
);

    pps_cmd_t    cmd;
    pps_status_t status;

    // sequencer
    pps_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // table and arithmetic
    pps_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .TIME_BITS     (TIME_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .slot            (slot),
        .arrival_time    (arrival_time),
        .burst_length    (burst_length),
        .priority_level  (priority_level),
        .done            (done),
        .ran             (ran),
        .process_number  (process_number),
        .slot_time       (slot_time),
        .switched        (switched),
        .completed       (completed),
        .finish_time     (finish_time),
        .waiting_time    (waiting_time),
        .turnaround_time (turnaround_time),
        .all_done        (all_done)
    );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// testbench for the preemptive priority scheduler core: directed and random transfers against a predictor
module tb_top;
    import pps_pkg::*;

    localparam int MAX_PROCS = 16;
    localparam int T_BITS = 16;
    localparam int P_BITS = 8;
    localparam logic [T_BITS-1:0] TIME_TOP = '1;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 160;
    localparam int RANDOM_ITEMS = 2000;
    localparam int RANDOM_CAP = 2400;
    localparam int SAT_TICKS_WANTED = 150;
    // the clock starts close to its top so that saturation is reached within the run
    localparam logic [T_BITS-1:0] CLOCK_BASE = 16'd64600;

    // sender idle percentage per phase: none, sender, receiver (cannot stall), both
    localparam int IDLE_PCT [4] = '{0, 52, 0, 15};
    localparam int COUNT_PLAN [8] = '{16, 3, 31, 1, 0, 8, 17, 2};

    typedef struct packed
    {
        logic                  kind;
        logic [SLOT_BITS-1:0]  slot;
        logic [T_BITS-1:0]     arrival;
        logic [T_BITS-1:0]     burst;
        logic [P_BITS-1:0]     prio;
    } sched_item_t;

    typedef struct packed
    {
        logic                  ran;
        logic [SLOT_BITS-1:0]  proc_num;
        logic [T_BITS-1:0]     unit_start;
        logic                  sw;
        logic                  comp;
        logic [T_BITS-1:0]     fin;
        logic [T_BITS-1:0]     wait_len;
        logic [T_BITS-1:0]     turn_len;
        logic                  all_done;
    } tick_report_t;

    // process table mirror, schedule prediction and result checking
    class sched_tracker;
        logic [T_BITS-1:0]     arrival_tab [MAX_PROCS];
        logic [T_BITS-1:0]     burst_tab [MAX_PROCS];
        logic [P_BITS-1:0]     prio_tab [MAX_PROCS];
        logic [T_BITS-1:0]     remaining_tab [MAX_PROCS];
        logic [COUNT_BITS-1:0] count;
        logic [T_BITS-1:0]     now;
        bit                    started;
        logic [SLOT_BITS-1:0]  prev_runner;
        bit                    prev_valid;
        tick_report_t          pending_reports [$];
        int unsigned           errors;
        int unsigned           items;
        int unsigned           ticks;
        int unsigned           completions;
        int unsigned           idles;
        int unsigned           all_done_ticks;
        int unsigned           saturated_ticks;

        function new();
            foreach (remaining_tab[i])
            begin
                arrival_tab[i] = '0;
                burst_tab[i] = '0;
                prio_tab[i] = '0;
                remaining_tab[i] = '0;
            end
            count = '0;
            now = '0;
            started = 0;
            prev_runner = '0;
            prev_valid = 0;
            errors = 0;
            items = 0;
            ticks = 0;
            completions = 0;
            idles = 0;
            all_done_ticks = 0;
            saturated_ticks = 0;
        endfunction

        // accepted input transfer: update the table or predict one tick report
        function void note_item(sched_item_t it);
            tick_report_t r;
            int unsigned n;
            int unsigned i;
            int unsigned best;
            int unsigned fin;
            int unsigned turn;
            bit found;
            bit work;
            items++;
            if (it.kind == KIND_LOAD)
            begin
                arrival_tab[it.slot] = it.arrival;
                burst_tab[it.slot] = it.burst;
                prio_tab[it.slot] = it.prio;
                remaining_tab[it.slot] = it.burst;
                return;
            end
            ticks++;
            n = (count > MAX_PROCS) ? MAX_PROCS : count;
            // clock start at the earliest arrival in use
            if (!started)
            begin
                now = '0;
                for (i = 0; i < n; i++)
                    if (i == 0 || arrival_tab[i] < now)
                        now = arrival_tab[i];
                started = 1;
            end
            r = '0;
            r.unit_start = now;
            if (now == TIME_TOP)
                saturated_ticks++;
            found = 0;
            work = 0;
            best = 0;
            // pick the arrived entry with the smallest priority, then earliest arrival
            for (i = 0; i < n; i++)
            begin
                if (remaining_tab[i] == 0)
                    continue;
                work = 1;
                if (arrival_tab[i] > now)
                    continue;
                if (!found || prio_tab[i] < prio_tab[best] ||
                    (prio_tab[i] == prio_tab[best] && arrival_tab[i] < arrival_tab[best]))
                begin
                    best = i;
                    found = 1;
                end
            end
            if (!work)
            begin
                r.all_done = 1'b1;
                all_done_ticks++;
            end
            else
            begin
                if (found)
                begin
                    r.ran = 1'b1;
                    r.proc_num = SLOT_BITS'(best);
                    r.sw = (!prev_valid || prev_runner != best);
                    prev_runner = SLOT_BITS'(best);
                    prev_valid = 1;
                    remaining_tab[best] = remaining_tab[best] - 1'b1;
                    if (remaining_tab[best] == 0)
                    begin
                        fin = (now != TIME_TOP) ? now + 32'd1 : now;
                        turn = (fin > arrival_tab[best]) ? fin - arrival_tab[best] : 0;
                        r.comp = 1'b1;
                        r.fin = T_BITS'(fin);
                        r.turn_len = T_BITS'(turn);
                        r.wait_len = T_BITS'((turn > burst_tab[best]) ? turn - burst_tab[best]
                                                                       : 0);
                        completions++;
                    end
                end
                else
                    idles++;
                if (now != TIME_TOP)
                    now = now + 1'b1;
            end
            pending_reports.insert(pending_reports.size(), r);
        endfunction

        function void report_bad(string what, int unsigned want, int unsigned got);
            errors++;
            if (errors <= 10)
                $display("mismatch in %s at %0t: expected %0d, got %0d", what, $time, want, got);
        endfunction

        // result transfer: compare with the oldest predicted report
        function void check_report(tick_report_t got);
            tick_report_t want;
            if (pending_reports.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result strobe with no tick pending at %0t", $time);
                return;
            end
            want = pending_reports.pop_front();
            if (got.ran !== want.ran)
                report_bad("ran", want.ran, got.ran);
            if (got.proc_num !== want.proc_num)
                report_bad("process_number", want.proc_num, got.proc_num);
            if (got.unit_start !== want.unit_start)
                report_bad("slot_time", want.unit_start, got.unit_start);
            if (got.sw !== want.sw)
                report_bad("switched", want.sw, got.sw);
            if (got.comp !== want.comp)
                report_bad("completed", want.comp, got.comp);
            if (got.fin !== want.fin)
                report_bad("finish_time", want.fin, got.fin);
            if (got.wait_len !== want.wait_len)
                report_bad("waiting_time", want.wait_len, got.wait_len);
            if (got.turn_len !== want.turn_len)
                report_bad("turnaround_time", want.turn_len, got.turn_len);
            if (got.all_done !== want.all_done)
                report_bad("all_done", want.all_done, got.all_done);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [COUNT_BITS-1:0] cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  kind = KIND_LOAD;
    logic [SLOT_BITS-1:0]  slot = '0;
    logic [T_BITS-1:0]     arrival_time = '0;
    logic [T_BITS-1:0]     burst_length = '0;
    logic [P_BITS-1:0]     priority_level = '0;
    logic                  done;
    logic                  ran;
    logic [SLOT_BITS-1:0]  process_number;
    logic [T_BITS-1:0]     slot_time;
    logic                  switched;
    logic                  completed;
    logic [T_BITS-1:0]     finish_time;
    logic [T_BITS-1:0]     waiting_time;
    logic [T_BITS-1:0]     turnaround_time;
    logic                  all_done;

    int unsigned cycle_count = 0;
    sched_tracker sb = new();

    preemptive_priority_scheduler_core dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .slot            (slot),
        .arrival_time    (arrival_time),
        .burst_length    (burst_length),
        .priority_level  (priority_level),
        .done            (done),
        .ran             (ran),
        .process_number  (process_number),
        .slot_time       (slot_time),
        .switched        (switched),
        .completed       (completed),
        .finish_time     (finish_time),
        .waiting_time    (waiting_time),
        .turnaround_time (turnaround_time),
        .all_done        (all_done)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // result monitor, sampled at the edge that ends the strobe cycle
    always @(posedge clk)
    begin : result_monitor
        tick_report_t got;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            got.ran = ran;
            got.proc_num = process_number;
            got.unit_start = slot_time;
            got.sw = switched;
            got.comp = completed;
            got.fin = finish_time;
            got.wait_len = waiting_time;
            got.turn_len = turnaround_time;
            got.all_done = all_done;
            sb.check_report(got);
        end
    end

    function automatic sched_item_t make_load(int unsigned s, int unsigned a, int unsigned b,
                                              int unsigned p);
        sched_item_t it;
        it.kind = KIND_LOAD;
        it.slot = SLOT_BITS'(s);
        it.arrival = T_BITS'(a);
        it.burst = T_BITS'(b);
        it.prio = P_BITS'(p);
        return it;
    endfunction

    function automatic sched_item_t make_tick();
        sched_item_t it;
        it = '0;
        it.kind = KIND_TICK;
        return it;
    endfunction

    // random transfer: arrivals mostly around the predicted clock, short bursts
    function automatic sched_item_t next_random_item();
        sched_item_t it;
        int unsigned pick;
        int unsigned t;
        int unsigned used;
        used = (sb.count > MAX_PROCS) ? MAX_PROCS : sb.count;
        it.kind = ($urandom_range(0, 99) < 58) ? KIND_TICK : KIND_LOAD;
        if (used >= 1 && $urandom_range(0, 3) != 0)
            it.slot = SLOT_BITS'($urandom_range(0, used - 1));
        else
            it.slot = SLOT_BITS'($urandom_range(0, MAX_PROCS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            t = sb.now + $urandom_range(0, 12);
            it.arrival = (t > TIME_TOP) ? TIME_TOP : T_BITS'(t);
        end
        else if (pick < 80)
        begin
            t = $urandom_range(0, 50);
            it.arrival = T_BITS'((sb.now > t) ? sb.now - t : 0);
        end
        else
            it.arrival = T_BITS'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10)
            it.burst = '0;
        else if (pick < 80)
            it.burst = T_BITS'($urandom_range(1, 6));
        else if (pick < 95)
            it.burst = T_BITS'($urandom_range(7, 40));
        else
            it.burst = T_BITS'($urandom);
        if ($urandom_range(0, 1) == 0)
            it.prio = P_BITS'($urandom_range(0, 7));
        else
            it.prio = P_BITS'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic int draw_gap(int pct);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < pct)
            gap++;
        return gap;
    endfunction

    // one input transfer; start stays high when the next follows back to back
    task automatic send_item(sched_item_t it, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        kind <= it.kind;
        slot <= it.slot;
        arrival_time <= it.arrival;
        burst_length <= it.burst;
        priority_level <= it.prio;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_item(it);
    endtask

    // hold off until every predicted report has arrived
    task automatic drain_all(int extra);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_reports.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // entry count register, written only while idle
    task automatic write_count(int unsigned value);
        drain_all(DRAIN_CYCLES);
        cfg_write <= 1'b1;
        cfg_data <= COUNT_BITS'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.count = COUNT_BITS'(value);
    endtask

    initial
    begin : stimulus
        int unsigned random_done;
        int unsigned phase;
        int pct;
        int k;

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full table, clock start, preemption, ties, zero burst, extremes
        write_count(MAX_PROCS);
        send_item(make_load(0, CLOCK_BASE + 5, 3, 10), 0);
        send_item(make_load(1, CLOCK_BASE + 2, 2, 4), 0);
        send_item(make_load(2, CLOCK_BASE, 4, 10), 0);
        send_item(make_load(3, CLOCK_BASE + 2, 1, 4), 0);
        send_item(make_load(4, CLOCK_BASE + 1, 0, 0), 0);
        send_item(make_load(5, TIME_TOP, TIME_TOP, 255), 0);
        for (k = 6; k < 14; k++)
            send_item(make_load(k, CLOCK_BASE + 20 + k, 1, 200), 0);
        send_item(make_load(14, CLOCK_BASE + 6, 1, 0), 0);
        send_item(make_load(15, CLOCK_BASE + 1, 2, 4), 0);
        for (k = 0; k < 9; k++)
            send_item(make_tick(), 0);

        // random phases over entry counts and idle patterns
        random_done = 0;
        phase = 0;
        while (random_done < RANDOM_CAP &&
               !(random_done >= RANDOM_ITEMS && sb.saturated_ticks >= SAT_TICKS_WANTED))
        begin
            if (phase < 8)
                write_count(COUNT_PLAN[phase]);
            else
                write_count($urandom_range(0, 31));
            pct = IDLE_PCT[phase % 4];
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 199) == 0)
                    drain_all(0);
                send_item(next_random_item(), draw_gap(pct));
                random_done++;
            end
            phase++;
        end

        // wrap up
        drain_all(DRAIN_CYCLES);
        $display("covered %0d transfers in %0d phases: %0d ticks, %0d completions, %0d idle",
                 sb.items, phase, sb.ticks, sb.completions, sb.idles);
        $display("all-done ticks %0d, ticks at saturated clock %0d, mismatches %0d",
                 sb.all_done_ticks, sb.saturated_ticks, sb.errors);
        if (sb.errors == 0 && sb.pending_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
